### rtl/session_table_lru_defines.svh
// Assertion macros for the session table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SESSION_TABLE_LRU_DEFINES_SVH
`define SESSION_TABLE_LRU_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define STL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/stl_pkg.sv
// Shared constants, request modes, register indexes and store structs
// for the session table. No dependencies.
package stl_pkg;

   localparam int NUM_ENTRIES = 64;
   localparam int ADDR_BITS   = 48;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

   // item field widths
   localparam int MODE_W = 3;
   localparam int PEER_W = 48;
   localparam int SID_W  = 32;
   localparam int SEL_W  = 6;
   localparam int TIME_W = 64;
   localparam int ACT_W  = 7;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIND_ADDR = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND_IDX  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOUCH     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FREE      = 3'd4;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_ACTION  = 1'd1;
   localparam logic [CSR_DATA_W-1:0] SLOTS_RESET = 7'd64;

   // full table behavior
   localparam logic FULL_REJECT = 1'b0;
   localparam logic FULL_EVICT  = 1'b1;

   // write request into the slot store
   typedef struct packed {
      logic                 alloc_en;
      logic                 touch_en;
      logic                 free_en;
      logic [IDX_W-1:0]     idx;
      logic [ADDR_BITS-1:0] addr;
      logic [SID_W-1:0]     sess;
      logic [TIME_W-1:0]    stamp;
   } store_wr_type;

   // registered read data of one slot
   typedef struct packed {
      logic                 active;
      logic [ADDR_BITS-1:0] addr;
      logic [SID_W-1:0]     sess;
      logic [TIME_W-1:0]    stamp;
   } store_rd_type;

endpackage

### rtl/stl_channels.sv
// Request and response channel interfaces of the session table.
// Depends on stl_pkg for the field widths.
interface stl_req_if;
   logic                         valid;
   logic                         ready;
   logic [stl_pkg::MODE_W-1:0]   mode;
   logic [stl_pkg::PEER_W-1:0]   peer_address;
   logic [stl_pkg::SID_W-1:0]    new_session_id;
   logic [stl_pkg::SEL_W-1:0]    slot_select;
   logic [stl_pkg::TIME_W-1:0]   now_time;

   modport source (output valid, mode, peer_address, new_session_id, slot_select, now_time,
                   input ready);
   modport sink   (input valid, mode, peer_address, new_session_id, slot_select, now_time,
                   output ready);
endinterface

interface stl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [stl_pkg::SEL_W-1:0]    slot_index;
   logic                         was_evicted;
   logic [stl_pkg::SID_W-1:0]    entry_session_id;
   logic [stl_pkg::ACT_W-1:0]    active_entries;

   modport source (output valid, hit, slot_index, was_evicted, entry_session_id,
                   active_entries, input ready);
   modport sink   (input valid, hit, slot_index, was_evicted, entry_session_id,
                   active_entries, output ready);
endinterface

### rtl/session_table_lru.sv
// Session table top: allocate/find/touch/free over 64 slots with LRU eviction.
// A full scan reads slots 0..L-1 (L = clamped limit); a first match stops it early;
// index modes read only the selected slot; an empty range (select out of range,
// unknown mode, full and reject) reads no slot. One item at a time: a new item
// is taken only when idle, and a response waiting at the output holds the next.
// Reset (synchronous): clears active/stamp flags, count, sequencer, response register;
// slots_in_use returns to 64, full_action to evict. No clearing pass.
`include "session_table_lru_defines.svh"

module session_table_lru (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [stl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   stl_req_if.sink                         req_chan,
   stl_rsp_if.source                       rsp_chan
);

   logic [stl_pkg::CSR_DATA_W-1:0] slots_in_use_ff, slots_in_use_in;
   logic                           full_action_ff, full_action_in;

   logic                           rd_en;
   logic [stl_pkg::IDX_W-1:0]      rd_idx;
   stl_pkg::store_rd_type          rd_data;
   stl_pkg::store_wr_type          wr;

   // configuration registers
   always_comb begin
      slots_in_use_in = slots_in_use_ff;
      full_action_in  = full_action_ff;
      if (csr_we) begin
         case (csr_index)
            stl_pkg::CSR_SLOTS_IN_USE: slots_in_use_in = csr_wdata;
            stl_pkg::CSR_FULL_ACTION:  full_action_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= stl_pkg::SLOTS_RESET;
         full_action_ff  <= stl_pkg::FULL_EVICT;
      end else begin
         slots_in_use_ff <= slots_in_use_in;
         full_action_ff  <= full_action_in;
      end
   end

   stl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .slots_in_use (slots_in_use_ff),
      .full_action  (full_action_ff),
      .rd_en        (rd_en),
      .rd_idx       (rd_idx),
      .rd_data      (rd_data),
      .wr           (wr)
   );

   stl_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // checks
   `STL_ASSERT_IMPLY(a_evict_needs_hit, clock, reset,
      rsp_chan.valid && rsp_chan.was_evicted, rsp_chan.hit,
      "eviction reported without a hit")
   `STL_ASSERT_IMPLY(a_miss_is_clean, clock, reset,
      rsp_chan.valid && !rsp_chan.hit,
      (rsp_chan.slot_index == '0) && (rsp_chan.entry_session_id == '0) && !rsp_chan.was_evicted,
      "miss response carries slot data")
   `STL_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready,
      "second item taken while one is in work")

endmodule

### rtl/stl_store.sv
// Slot store: address, session and timestamp memories with registered reads,
// plus active and stamped flag vectors. Depends on stl_pkg.
module stl_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [stl_pkg::IDX_W-1:0]    rd_idx,
   output stl_pkg::store_rd_type        rd_data,
   input  stl_pkg::store_wr_type        wr
);

   logic [stl_pkg::ADDR_BITS-1:0] addr_mem [stl_pkg::NUM_ENTRIES];
   logic [stl_pkg::SID_W-1:0]     sess_mem [stl_pkg::NUM_ENTRIES];
   logic [stl_pkg::TIME_W-1:0]    time_mem [stl_pkg::NUM_ENTRIES];

   logic [stl_pkg::NUM_ENTRIES-1:0] active_ff, active_in;
   logic [stl_pkg::NUM_ENTRIES-1:0] stamped_ff, stamped_in;

   logic [stl_pkg::ADDR_BITS-1:0] addr_rd_ff;
   logic [stl_pkg::SID_W-1:0]     sess_rd_ff;
   logic [stl_pkg::TIME_W-1:0]    time_rd_ff;
   logic                          active_rd_ff;
   logic                          stamped_rd_ff;

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (wr.alloc_en) begin
         addr_mem[wr.idx] <= wr.addr;
         sess_mem[wr.idx] <= wr.sess;
      end
      if (wr.touch_en) begin
         time_mem[wr.idx] <= wr.stamp;
      end
      if (rd_en) begin
         addr_rd_ff    <= addr_mem[rd_idx];
         sess_rd_ff    <= sess_mem[rd_idx];
         time_rd_ff    <= time_mem[rd_idx];
         active_rd_ff  <= active_ff[rd_idx];
         stamped_rd_ff <= stamped_ff[rd_idx];
      end
   end

   // flag updates: allocate sets active, free clears it, touch marks stamped
   always_comb begin
      active_in  = active_ff;
      stamped_in = stamped_ff;
      if (wr.alloc_en) begin
         active_in[wr.idx] = 1'b1;
      end
      if (wr.free_en) begin
         active_in[wr.idx] = 1'b0;
      end
      if (wr.touch_en) begin
         stamped_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         stamped_ff <= '0;
      end else begin
         active_ff  <= active_in;
         stamped_ff <= stamped_in;
      end
   end

   // a slot never touched reads time zero
   assign rd_data.active = active_rd_ff;
   assign rd_data.addr   = addr_rd_ff;
   assign rd_data.sess   = sess_rd_ff;
   assign rd_data.stamp  = stamped_rd_ff ? time_rd_ff : '0;

endmodule

### rtl/stl_seq.sv
// Request sequencer: scans slots through the store, one read per cycle,
// picks the match or LRU victim, writes back and holds the response item.
// Depends on stl_pkg (including the store read/write structs) and stl_channels.
module stl_seq (
   input  logic                            clock,
   input  logic                            reset,
   stl_req_if.sink                         req_chan,
   stl_rsp_if.source                       rsp_chan,
   input  logic [stl_pkg::CSR_DATA_W-1:0]  slots_in_use,
   input  logic                            full_action,
   output logic                            rd_en,
   output logic [stl_pkg::IDX_W-1:0]       rd_idx,
   input  stl_pkg::store_rd_type           rd_data,
   output stl_pkg::store_wr_type           wr
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [stl_pkg::CNT_W-1:0] CNT_MAX = stl_pkg::CNT_W'(stl_pkg::NUM_ENTRIES);

   logic [1:0]                     state_ff, state_in;
   logic [stl_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [stl_pkg::ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [stl_pkg::SID_W-1:0]      sid_ff, sid_in;
   logic [stl_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [stl_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [stl_pkg::CNT_W-1:0]      end_ff, end_in;
   logic                           lru_ff, lru_in;
   logic                           pend_ff, pend_in;
   logic [stl_pkg::IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                           found_ff, found_in;
   logic [stl_pkg::IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [stl_pkg::TIME_W-1:0]     best_time_ff, best_time_in;
   logic [stl_pkg::SID_W-1:0]      sess_ff, sess_in;
   logic [stl_pkg::ACT_W-1:0]      total_ff, total_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [stl_pkg::SEL_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                           rsp_evict_ff, rsp_evict_in;
   logic [stl_pkg::SID_W-1:0]      rsp_sess_ff, rsp_sess_in;
   logic [stl_pkg::ACT_W-1:0]      rsp_total_ff, rsp_total_in;

   logic                           accept;
   logic                           issue;
   logic                           halted;
   logic                           take;
   logic                           done_go;
   logic [stl_pkg::CNT_W-1:0]      lim;
   logic [stl_pkg::CNT_W-1:0]      sel_ext;
   logic [stl_pkg::CNT_W-1:0]      start_cnt;
   logic [stl_pkg::CNT_W-1:0]      stop_cnt;
   logic                           start_lru;
   logic [stl_pkg::SID_W-1:0]      take_sess;

   // handshake and slot limit clamped to 1..NUM_ENTRIES
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept  = req_chan.valid && req_chan.ready;
   assign lim     = (slots_in_use == '0) ? stl_pkg::CNT_W'(1) :
                    (slots_in_use > CNT_MAX) ? CNT_MAX : slots_in_use;
   assign sel_ext = stl_pkg::CNT_W'(req_chan.slot_select);

   // scan range for the new item; an empty range is a miss
   always_comb begin
      start_cnt = '0;
      stop_cnt  = '0;
      start_lru = 1'b0;
      case (req_chan.mode)
         stl_pkg::MODE_ALLOC: begin
            if (total_ff < lim) begin
               stop_cnt = lim;
            end else if (full_action == stl_pkg::FULL_EVICT) begin
               stop_cnt  = lim;
               start_lru = 1'b1;
            end
         end
         stl_pkg::MODE_FIND_ADDR: begin
            stop_cnt = lim;
         end
         stl_pkg::MODE_FIND_IDX, stl_pkg::MODE_TOUCH, stl_pkg::MODE_FREE: begin
            if (sel_ext < lim) begin
               start_cnt = sel_ext;
               stop_cnt  = sel_ext + stl_pkg::CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // first-match searches stop once found; the LRU search covers every slot up to the limit
   assign halted  = found_ff && !lru_ff;
   assign issue   = (state_ff == ST_SCAN) && (cnt_ff < end_ff) && !halted;
   assign rd_en   = issue;
   assign rd_idx  = cnt_ff[stl_pkg::IDX_W-1:0];
   assign done_go = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // judge the slot whose read data arrives this cycle
   always_comb begin
      take      = 1'b0;
      take_sess = '0;
      if (pend_ff && !halted) begin
         case (mode_ff)
            stl_pkg::MODE_ALLOC: begin
               take      = lru_ff ? (rd_data.active &&
                                     (!found_ff || rd_data.stamp < best_time_ff))
                                  : !rd_data.active;
               take_sess = sid_ff;
            end
            stl_pkg::MODE_FIND_ADDR: begin
               take      = rd_data.active && (rd_data.addr == addr_ff);
               take_sess = rd_data.sess;
            end
            stl_pkg::MODE_FIND_IDX: begin
               take      = rd_data.active;
               take_sess = rd_data.sess;
            end
            stl_pkg::MODE_TOUCH: begin
               take      = 1'b1;
               take_sess = rd_data.active ? rd_data.sess : '0;
            end
            stl_pkg::MODE_FREE: begin
               take      = rd_data.active;
               take_sess = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      sid_in       = sid_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      lru_in       = lru_ff;
      pend_in      = issue;
      pend_idx_in  = cnt_ff[stl_pkg::IDX_W-1:0];
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      sess_in      = sess_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               mode_in  = req_chan.mode;
               addr_in  = req_chan.peer_address[stl_pkg::ADDR_BITS-1:0];
               sid_in   = req_chan.new_session_id;
               now_in   = req_chan.now_time;
               cnt_in   = start_cnt;
               end_in   = stop_cnt;
               lru_in   = start_lru;
               found_in = 1'b0;
               sess_in  = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + stl_pkg::CNT_W'(1);
            end
            if (take) begin
               found_in     = 1'b1;
               best_idx_in  = pend_idx_ff;
               best_time_in = rd_data.stamp;
               sess_in      = take_sess;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // write-back of the finished item
   assign wr.alloc_en = done_go && found_ff && (mode_ff == stl_pkg::MODE_ALLOC);
   assign wr.touch_en = done_go && found_ff && (mode_ff == stl_pkg::MODE_TOUCH);
   assign wr.free_en  = done_go && found_ff && (mode_ff == stl_pkg::MODE_FREE);
   assign wr.idx      = best_idx_ff;
   assign wr.addr     = addr_ff;
   assign wr.sess     = sid_ff;
   assign wr.stamp    = now_ff;

   // active count: eviction reuses a slot, so only a fresh allocate counts up
   always_comb begin
      total_in = total_ff;
      if (wr.alloc_en && !lru_ff) begin
         total_in = total_ff + stl_pkg::ACT_W'(1);
      end else if (wr.free_en && (total_ff != '0)) begin
         total_in = total_ff - stl_pkg::ACT_W'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_sess_in  = rsp_sess_ff;
      rsp_total_in = rsp_total_ff;
      if (done_go) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = found_ff;
         rsp_idx_in   = found_ff ? best_idx_ff : '0;
         rsp_evict_in = found_ff && lru_ff;
         rsp_sess_in  = sess_ff;
         rsp_total_in = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      addr_ff      <= addr_in;
      sid_ff       <= sid_in;
      now_ff       <= now_in;
      cnt_ff       <= cnt_in;
      end_ff       <= end_in;
      lru_ff       <= lru_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      sess_ff      <= sess_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_sess_ff  <= rsp_sess_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hit              = rsp_hit_ff;
   assign rsp_chan.slot_index       = rsp_idx_ff;
   assign rsp_chan.was_evicted      = rsp_evict_ff;
   assign rsp_chan.entry_session_id = rsp_sess_ff;
   assign rsp_chan.active_entries   = rsp_total_ff;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for session_table_lru: drives requests and register writes,
// predicts every response with its own copy of the table and checks it field by field.
// Depends on stl_pkg and the stl_req_if / stl_rsp_if channel interfaces.
module tb_top;

   // highest mode code, unknown to the block
   localparam logic [stl_pkg::MODE_W-1:0] MODE_LAST = '1;
   localparam int DRAIN_CYCLES = stl_pkg::NUM_ENTRIES + 8;     // longest scan plus margin
   localparam int POOL_SIZE = 16;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [stl_pkg::MODE_W-1:0] mode;
      logic [stl_pkg::PEER_W-1:0] peer_address;
      logic [stl_pkg::SID_W-1:0]  new_session_id;
      logic [stl_pkg::SEL_W-1:0]  slot_select;
      logic [stl_pkg::TIME_W-1:0] now_time;
   } request_type;

   typedef struct packed {
      logic                       hit;
      logic [stl_pkg::SEL_W-1:0]  slot_index;
      logic                       was_evicted;
      logic [stl_pkg::SID_W-1:0]  entry_session_id;
      logic [stl_pkg::ACT_W-1:0]  active_entries;
   } answer_type;

   // Table predictor plus the queue of answers still owed by the block
   class session_scoreboard_type;
      bit                             active [stl_pkg::NUM_ENTRIES];
      logic [stl_pkg::ADDR_BITS-1:0]  address [stl_pkg::NUM_ENTRIES];
      logic [stl_pkg::SID_W-1:0]      session [stl_pkg::NUM_ENTRIES];
      logic [stl_pkg::TIME_W-1:0]     last_used [stl_pkg::NUM_ENTRIES];
      int                             total;
      logic [stl_pkg::CSR_DATA_W-1:0] slots_cfg;
      logic                           full_cfg;
      answer_type                     answers_due [$];
      int mismatch_count;
      int requests_seen;
      int answers_checked;
      int evictions;
      int alloc_misses;
      int lookup_hits;

      function new();
         int i;
         for (i = 0; i < stl_pkg::NUM_ENTRIES; i++) begin
            active[i] = 1'b0;
            address[i] = '0;
            session[i] = '0;
            last_used[i] = '0;
         end
         total = 0;
         slots_cfg = stl_pkg::SLOTS_RESET;
         full_cfg = stl_pkg::FULL_EVICT;
         mismatch_count = 0;
         requests_seen = 0;
         answers_checked = 0;
         evictions = 0;
         alloc_misses = 0;
         lookup_hits = 0;
      endfunction

      function void set_config(logic [stl_pkg::CSR_IDX_W-1:0] idx,
                               logic [stl_pkg::CSR_DATA_W-1:0] data);
         if (idx == stl_pkg::CSR_SLOTS_IN_USE) slots_cfg = data;
         else full_cfg = data[0];
      endfunction

      // Update the table copy for one request and return the answer it must give
      function answer_type apply_request(request_type r);
         answer_type a;
         int lim;
         int i;
         int idx;
         bit found;
         logic [stl_pkg::TIME_W-1:0] oldest;
         a = '0;
         idx = 0;
         found = 1'b0;
         oldest = '0;
         lim = int'(slots_cfg);
         if (lim < 1) lim = 1;
         if (lim > stl_pkg::NUM_ENTRIES) lim = stl_pkg::NUM_ENTRIES;
         case (r.mode)
            stl_pkg::MODE_ALLOC: begin
               if (total < lim) begin
                  for (i = 0; i < lim && !found; i++) begin
                     if (!active[i]) begin
                        idx = i;
                        found = 1'b1;
                     end
                  end
               end else if (full_cfg == stl_pkg::FULL_EVICT) begin
                  // oldest stamp among active slots, lowest index on ties
                  for (i = 0; i < lim; i++) begin
                     if (active[i] && (!found || last_used[i] < oldest)) begin
                        oldest = last_used[i];
                        idx = i;
                        found = 1'b1;
                     end
                  end
                  if (found) begin
                     a.was_evicted = 1'b1;
                     active[idx] = 1'b0;
                     total--;
                     evictions++;
                  end
               end
               if (found) begin
                  session[idx] = r.new_session_id;
                  address[idx] = r.peer_address[stl_pkg::ADDR_BITS-1:0];
                  active[idx] = 1'b1;
                  total++;
                  a.hit = 1'b1;
                  a.slot_index = stl_pkg::SEL_W'(idx);
                  a.entry_session_id = r.new_session_id;
               end else begin
                  alloc_misses++;
               end
            end
            stl_pkg::MODE_FIND_ADDR: begin
               for (i = 0; i < lim && !found; i++) begin
                  if (active[i] && address[i] == r.peer_address[stl_pkg::ADDR_BITS-1:0]) begin
                     found = 1'b1;
                     a.hit = 1'b1;
                     a.slot_index = stl_pkg::SEL_W'(i);
                     a.entry_session_id = session[i];
                     lookup_hits++;
                  end
               end
            end
            stl_pkg::MODE_FIND_IDX: begin
               if (r.slot_select < lim && active[r.slot_select]) begin
                  a.hit = 1'b1;
                  a.slot_index = r.slot_select;
                  a.entry_session_id = session[r.slot_select];
                  lookup_hits++;
               end
            end
            stl_pkg::MODE_TOUCH: begin
               // stamps inactive slots as well
               if (r.slot_select < lim) begin
                  last_used[r.slot_select] = r.now_time;
                  a.hit = 1'b1;
                  a.slot_index = r.slot_select;
                  a.entry_session_id = active[r.slot_select] ? session[r.slot_select] : '0;
               end
            end
            stl_pkg::MODE_FREE: begin
               if (r.slot_select < lim && active[r.slot_select]) begin
                  active[r.slot_select] = 1'b0;
                  session[r.slot_select] = '0;
                  if (total > 0) total--;
                  a.hit = 1'b1;
                  a.slot_index = r.slot_select;
               end
            end
            default: ;  // unknown modes change nothing
         endcase
         a.active_entries = stl_pkg::ACT_W'(total);
         return a;
      endfunction

      function void note_request(request_type r);
         answers_due.push_back(apply_request(r));
         requests_seen++;
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d field %s: got %0h, want %0h",
                                      answers_checked, name, got, want));
      endtask

      task check_response(answer_type got);
         answer_type want;
         answers_checked++;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      answers_checked));
         end else begin
            want = answers_due.pop_front();
            compare_field("hit", got.hit, want.hit);
            compare_field("slot_index", got.slot_index, want.slot_index);
            compare_field("was_evicted", got.was_evicted, want.was_evicted);
            compare_field("entry_session_id", got.entry_session_id, want.entry_session_id);
            compare_field("active_entries", got.active_entries, want.active_entries);
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [stl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [stl_pkg::CSR_DATA_W-1:0] csr_wdata;

   stl_req_if req_chan ();
   stl_rsp_if rsp_chan ();

   session_scoreboard_type     table_sb;
   int                         stall_pct;
   int                         settings_used;
   logic [stl_pkg::TIME_W-1:0] time_base;
   logic [stl_pkg::PEER_W-1:0] addr_pool [POOL_SIZE];

   session_table_lru u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic request_type make_request(logic [stl_pkg::MODE_W-1:0] mode,
                                                logic [stl_pkg::PEER_W-1:0] peer,
                                                logic [stl_pkg::SID_W-1:0] sid,
                                                logic [stl_pkg::SEL_W-1:0] sel,
                                                logic [stl_pkg::TIME_W-1:0] now);
      request_type r;
      r.mode = mode;
      r.peer_address = peer;
      r.new_session_id = sid;
      r.slot_select = sel;
      r.now_time = now;
      return r;
   endfunction

   // Random request; addresses mostly from a small pool so lookups hit and duplicate
   function automatic request_type random_request(int lim, int alloc_weight);
      request_type r;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < alloc_weight) r.mode = stl_pkg::MODE_ALLOC;
      else if (roll < alloc_weight + 15) r.mode = stl_pkg::MODE_FIND_ADDR;
      else if (roll < alloc_weight + 30) r.mode = stl_pkg::MODE_FIND_IDX;
      else if (roll < alloc_weight + 50) r.mode = stl_pkg::MODE_TOUCH;
      else if (roll < 97) r.mode = stl_pkg::MODE_FREE;
      else r.mode = stl_pkg::MODE_W'($urandom_range(int'(stl_pkg::MODE_FREE) + 1,
                                                    int'(MODE_LAST)));

      if ($urandom_range(0, 99) < 70)
         r.peer_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         r.peer_address = stl_pkg::PEER_W'({$urandom, $urandom});
      r.new_session_id = $urandom;

      // mostly inside the limit or just past it
      if ($urandom_range(0, 99) < 80)
         r.slot_select = stl_pkg::SEL_W'($urandom_range(0, (lim < stl_pkg::NUM_ENTRIES) ?
                                                        lim : stl_pkg::NUM_ENTRIES - 1));
      else
         r.slot_select = stl_pkg::SEL_W'($urandom);

      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         time_base += $urandom_range(1, 500);
         r.now_time = time_base;
      end else if (roll < 80) begin
         r.now_time = time_base;       // same stamp as the last one, gives ties
      end else if (roll < 85) begin
         r.now_time = '0;
      end else if (roll < 90) begin
         r.now_time = '1;
      end else begin
         r.now_time = {$urandom, $urandom};
      end
      return r;
   endfunction

   // Receiver: random backpressure at the current stall rate
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watch both channels; values sampled here are the ones seen by the block at this edge
   always @(posedge clock) begin
      answer_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            table_sb.note_request(make_request(req_chan.mode, req_chan.peer_address,
                                               req_chan.new_session_id,
                                               req_chan.slot_select, req_chan.now_time));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hit = rsp_chan.hit;
            got.slot_index = rsp_chan.slot_index;
            got.was_evicted = rsp_chan.was_evicted;
            got.entry_session_id = rsp_chan.entry_session_id;
            got.active_entries = rsp_chan.active_entries;
            table_sb.check_response(got);
         end
      end
   end

   task automatic send_item(request_type r, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= r.mode;
      req_chan.peer_address <= r.peer_address;
      req_chan.new_session_id <= r.new_session_id;
      req_chan.slot_select <= r.slot_select;
      req_chan.now_time <= r.now_time;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every owed response has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (table_sb.answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [stl_pkg::CSR_IDX_W-1:0] idx,
                            logic [stl_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      table_sb.set_config(idx, data);
      @(posedge clock);
   endtask

   task automatic run_phase(logic [stl_pkg::CSR_DATA_W-1:0] slots, logic full, int count,
                            int send_idle, int recv_stall, int alloc_weight);
      int lim;
      wait_drained();
      write_csr(stl_pkg::CSR_SLOTS_IN_USE, slots);
      write_csr(stl_pkg::CSR_FULL_ACTION, stl_pkg::CSR_DATA_W'(full));
      lim = (slots == 0) ? 1 :
            (slots > stl_pkg::NUM_ENTRIES) ? stl_pkg::NUM_ENTRIES : int'(slots);
      stall_pct = recv_stall;
      settings_used++;
      repeat (count) send_item(random_request(lim, alloc_weight), send_idle);
   endtask

   // Main sequence
   initial begin
      int m;
      int i;
      table_sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = stl_pkg::CSR_SLOTS_IN_USE;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = stl_pkg::MODE_ALLOC;
      req_chan.peer_address = '0;
      req_chan.new_session_id = '0;
      req_chan.slot_select = '0;
      req_chan.now_time = '0;
      stall_pct = 0;
      settings_used = 1;
      time_base = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) addr_pool[i] = stl_pkg::PEER_W'({$urandom, $urandom});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: lookups and frees miss, touch still stamps (largest time)
      send_item(make_request(stl_pkg::MODE_FIND_IDX, '0, '0, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_FREE, '0, '0, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_TOUCH, '0, '0,
                             stl_pkg::SEL_W'(stl_pkg::NUM_ENTRIES - 1), '1), 0);
      for (m = int'(stl_pkg::MODE_FREE) + 1; m <= int'(MODE_LAST); m++)
         send_item(make_request(stl_pkg::MODE_W'(m), '1, '1, '1, '1), 0);

      // fill a few slots, one address twice
      send_item(make_request(stl_pkg::MODE_ALLOC, '0, '0, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_ALLOC, '1, '1, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_ALLOC, addr_pool[2], $urandom, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_ALLOC, '1, 32'h5a5a_a5a5, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_FIND_ADDR, '1, '0, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_FIND_ADDR, addr_pool[3], '0, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_FIND_IDX, '0, '0, stl_pkg::SEL_W'(1), '0), 0);
      send_item(make_request(stl_pkg::MODE_TOUCH, '0, '0, stl_pkg::SEL_W'(2), '0), 0);
      send_item(make_request(stl_pkg::MODE_FREE, '0, '0, stl_pkg::SEL_W'(0), '0), 0);
      send_item(make_request(stl_pkg::MODE_FREE, '0, '0, stl_pkg::SEL_W'(0), '0), 0);
      send_item(make_request(stl_pkg::MODE_FREE, '0, '0, stl_pkg::SEL_W'(1), '0), 0);

      // limit lowered below the active slots: eviction finds nothing, selects out of range
      wait_drained();
      write_csr(stl_pkg::CSR_SLOTS_IN_USE, 7'd2);
      send_item(make_request(stl_pkg::MODE_ALLOC, addr_pool[4], $urandom, '0, '0), 0);
      send_item(make_request(stl_pkg::MODE_TOUCH, '0, '0, stl_pkg::SEL_W'(5), 64'd7), 0);
      send_item(make_request(stl_pkg::MODE_FIND_IDX, '0, '0, stl_pkg::SEL_W'(2), '0), 0);

      // a limit of zero acts as one
      wait_drained();
      write_csr(stl_pkg::CSR_SLOTS_IN_USE, 7'd0);
      send_item(make_request(stl_pkg::MODE_ALLOC, addr_pool[5], $urandom, '0, '0), 0);

      // random phases over register settings and idle patterns
      run_phase(7'd4, stl_pkg::FULL_EVICT, 140, 0, 0, 30);
      run_phase(7'd1, stl_pkg::FULL_REJECT, 60, 60, 0, 30);
      run_phase(7'd8, stl_pkg::FULL_EVICT, 140, 0, 60, 30);
      run_phase(7'd3, stl_pkg::FULL_REJECT, 100, 35, 35, 30);
      run_phase(stl_pkg::SLOTS_RESET, stl_pkg::FULL_EVICT, 200, 35, 35, 45);
      run_phase(7'd127, stl_pkg::FULL_EVICT, 100, 0, 0, 20);
      run_phase(7'd0, stl_pkg::FULL_EVICT, 60, 60, 0, 30);
      run_phase(7'd6, stl_pkg::FULL_REJECT, 80, 0, 60, 30);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses to %0d requests over %0d register settings",
               table_sb.answers_checked, table_sb.requests_seen, settings_used);
      $display("Evicting allocations %0d, missed allocations %0d, lookup hits %0d",
               table_sb.evictions, table_sb.alloc_misses, table_sb.lookup_hits);
      if (table_sb.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("Timeout with %0d responses outstanding", table_sb.answers_due.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
